// File: rtl/core/eisc_pkg.sv
package eisc_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [1:0] REG_DEFAULT_LIMIT = 2'd1;

  localparam logic [15:0] TIME_STEP_RST     = 16'd1092;
  localparam logic [30:0] DEFAULT_LIMIT_RST = 31'd65536000;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] acc;
    logic [30:0]      speed_limit;
    logic             limit_present;
  } in_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] mag;
    logic [30:0]      limit;
    logic [63:0]      s;
    logic             clamp;
    logic             sat;
  } qe_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  function automatic logic signed [48:0] mul_dt(input logic [31:0] x, input logic [15:0] dt);
    logic signed [48:0] p;
    p = $signed({{17{x[31]}}, x}) * $signed({33'd0, dt});
    return p;
  endfunction

  // halves round toward plus infinity
  function automatic logic [32:0] round_dt(input logic signed [48:0] p);
    logic signed [48:0] b;
    b = p + 49'sd32768;
    return b[48:16];
  endfunction

  function automatic sat_t sat32(input logic [33:0] x);
    sat_t r;
    r.sat = !((x[33:31] == 3'b000) || (x[33:31] == 3'b111));
    if (r.sat) begin
      r.val = x[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.val = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [33:0] add_rounded(input logic [31:0] a, input logic [32:0] r);
    return {{2{a[31]}}, a} + {r[32], r};
  endfunction

endpackage

// File: rtl/core/euler_integrate_speed_clamp_top.sv
// Euler step with speed clamp: one particle item per cycle sustained while the output is not held.
// The path from input accept to result valid runs through four front stages,
// the queue, a 32-stage square root and a 31-stage restoring divider.
// A four-entry queue splits the front from the back so each side stalls alone.
// Synchronous active-high reset empties all pipelines and the queue and loads
// time_step = 1092 and default_speed_limit = 65536000.
module euler_integrate_speed_clamp_top
  import eisc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] acc_x,
  input  logic signed [31:0] acc_y,
  input  logic signed [31:0] acc_z,
  input  logic [30:0]        speed_limit,
  input  logic               limit_present,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_pos_z,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_vel_z,
  output logic               speed_clamped,
  output logic               saturated
);

  logic [15:0]      time_step;
  logic [30:0]      default_speed_limit;
  in_t              in_item;
  logic             push, full, pop, nonempty;
  qe_t              push_item, head;
  logic [2:0][31:0] np, nv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step           <= TIME_STEP_RST;
      default_speed_limit <= DEFAULT_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_STEP:     time_step <= cfg_data[15:0];
        REG_DEFAULT_LIMIT: default_speed_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign in_item.pos           = {pos_z, pos_y, pos_x};
  assign in_item.vel           = {vel_z, vel_y, vel_x};
  assign in_item.acc           = {acc_z, acc_y, acc_x};
  assign in_item.speed_limit   = speed_limit;
  assign in_item.limit_present = limit_present;

  eisc_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_item             (in_item),
    .time_step           (time_step),
    .default_speed_limit (default_speed_limit),
    .push                (push),
    .push_item           (push_item),
    .full                (full)
  );

  eisc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  eisc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .time_step     (time_step),
    .q_nonempty    (nonempty),
    .pop           (pop),
    .head          (head),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_pos       (np),
    .new_vel       (nv),
    .speed_clamped (speed_clamped),
    .saturated     (saturated)
  );

  assign new_pos_x = np[0];
  assign new_pos_y = np[1];
  assign new_pos_z = np[2];
  assign new_vel_x = nv[0];
  assign new_vel_y = nv[1];
  assign new_vel_z = nv[2];

endmodule

// File: rtl/core/eisc_front.sv
module eisc_front
  import eisc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  input  logic [15:0] time_step,
  input  logic [30:0] default_speed_limit,
  output logic        push,
  output qe_t         push_item,
  input  logic        full
);

  typedef struct packed {
    logic [2:0][31:0]        pos;
    logic [2:0][31:0]        vel;
    logic [2:0][48:0]        prod;
    logic [30:0]             limit;
  } f1_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] mag;
    logic [30:0]      limit;
    logic             sat;
  } f2_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] mag;
    logic [2:0][63:0] sq;
    logic [30:0]      limit;
    logic [61:0]      lim2;
    logic             sat;
  } f3_t;

  f1_t  f1;
  f2_t  f2;
  f3_t  f3;
  qe_t  f4;
  logic f1_valid, f2_valid, f3_valid, f4_valid;
  logic fe;

  // hold the whole front while the last stage cannot push
  assign fe       = !(f4_valid && full);
  assign in_ready = fe;
  assign push     = f4_valid && !full;
  assign push_item = f4;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
    end else if (fe) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
    end
  end

  always_ff @(posedge clk) begin
    sat_t  sv;
    logic [31:0] v;
    logic  any_sat;
    if (fe) begin
      f1.pos   <= in_item.pos;
      f1.vel   <= in_item.vel;
      f1.limit <= in_item.limit_present ? in_item.speed_limit : default_speed_limit;
      for (int k = 0; k < 3; k++) begin
        f1.prod[k] <= mul_dt(in_item.acc[k], time_step);
      end

      any_sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
        sv = sat32(add_rounded(f1.vel[k], round_dt($signed(f1.prod[k]))));
        v  = sv.val;
        any_sat = any_sat | sv.sat;
        f2.vel[k] <= v;
        f2.mag[k] <= v[31] ? (~v + 32'd1) : v;
      end
      f2.pos   <= f1.pos;
      f2.limit <= f1.limit;
      f2.sat   <= any_sat;

      for (int k = 0; k < 3; k++) begin
        f3.sq[k] <= {32'd0, f2.mag[k]} * {32'd0, f2.mag[k]};
      end
      f3.lim2  <= {31'd0, f2.limit} * {31'd0, f2.limit};
      f3.pos   <= f2.pos;
      f3.vel   <= f2.vel;
      f3.mag   <= f2.mag;
      f3.limit <= f2.limit;
      f3.sat   <= f2.sat;

      f4.s     <= f3.sq[0] + f3.sq[1] + f3.sq[2];
      f4.clamp <= (f3.sq[0] + f3.sq[1] + f3.sq[2]) > {2'd0, f3.lim2};
      f4.pos   <= f3.pos;
      f4.vel   <= f3.vel;
      f4.mag   <= f3.mag;
      f4.limit <= f3.limit;
      f4.sat   <= f3.sat;
    end
  end

endmodule

// File: rtl/core/eisc_queue.sv
module eisc_queue
  import eisc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  qe_t  push_item,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output qe_t  head
);

  qe_t            mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign full     = (count == QDEPTH[QAW:0]);
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/core/eisc_back.sv
module eisc_back
  import eisc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      time_step,
  input  logic             q_nonempty,
  output logic             pop,
  input  qe_t              head,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0][31:0] new_pos,
  output logic [2:0][31:0] new_vel,
  output logic             speed_clamped,
  output logic             saturated
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam int S_DINIT   = SQ_STEPS + 1;
  localparam int S_VEL     = S_DINIT + DIV_STEPS + 1;
  localparam int S_OUT     = S_VEL + 1;
  localparam int NST       = S_OUT + 1;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [30:0]      limit;
    logic             clamp;
    logic             sat;
    logic [63:0]      n;
    logic [63:0]      r;
    logic [31:0]      m;
    logic [2:0][62:0] num;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] q;
    logic [2:0][48:0] pd;
  } bk_t;

  bk_t            st [NST];
  logic [NST-1:0] sv;
  logic           be;

  // advance all stages together unless the output is held
  assign be        = !sv[NST-1] || out_ready;
  assign pop       = be && q_nonempty;
  assign out_valid = sv[NST-1];

  function automatic bk_t sqrt_step(input bk_t x, input logic [63:0] b);
    bk_t y;
    y = x;
    if (x.n >= x.r + b) begin
      y.n = x.n - (x.r + b);
      y.r = (x.r >> 1) + b;
    end else begin
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  function automatic bk_t div_step(input bk_t x, input int j);
    bk_t        y;
    logic [32:0] t;
    y = x;
    for (int k = 0; k < 3; k++) begin
      t = {x.rem[k], x.num[k][DIV_STEPS-1-j]};
      if (t >= {1'b0, x.m}) begin
        t        = t - {1'b0, x.m};
        y.q[k]   = {x.q[k][DIV_STEPS-2:0], 1'b1};
      end else begin
        y.q[k]   = {x.q[k][DIV_STEPS-2:0], 1'b0};
      end
      y.rem[k] = t[31:0];
    end
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (be) begin
      sv <= {sv[NST-2:0], q_nonempty};
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      st[0].pos   <= head.pos;
      st[0].vel   <= head.vel;
      st[0].limit <= head.limit;
      st[0].clamp <= head.clamp;
      st[0].sat   <= head.sat;
      st[0].n     <= head.s;
      st[0].r     <= '0;
      st[0].m     <= '0;
      st[0].rem   <= '0;
      st[0].q     <= '0;
      st[0].pd    <= '0;
      for (int k = 0; k < 3; k++) begin
        st[0].num[k] <= 63'({31'd0, head.mag[k]} * {32'd0, head.limit});
      end
    end
  end

  for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (i - 1));
    always_ff @(posedge clk) begin
      if (be) begin
        st[i] <= sqrt_step(st[i-1], BIT);
      end
    end
  end

  // start the division: high numerator bits are already below the root
  always_ff @(posedge clk) begin
    bk_t x;
    x = st[S_DINIT-1];
    x.m = x.r[31:0];
    for (int k = 0; k < 3; k++) begin
      x.rem[k] = x.num[k][62:DIV_STEPS];
      x.q[k]   = '0;
    end
    if (be) begin
      st[S_DINIT] <= x;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (be) begin
        st[S_DINIT+1+j] <= div_step(st[S_DINIT+j], j);
      end
    end
  end

  always_ff @(posedge clk) begin
    bk_t         x;
    logic [31:0] qv;
    x = st[S_VEL-1];
    for (int k = 0; k < 3; k++) begin
      qv = {1'b0, x.q[k]};
      if (x.clamp) begin
        x.vel[k] = x.vel[k][31] ? (~qv + 32'd1) : qv;
      end
      x.pd[k] = mul_dt(x.vel[k], time_step);
    end
    if (be) begin
      st[S_VEL] <= x;
    end
  end

  always_ff @(posedge clk) begin
    bk_t  x;
    sat_t sr;
    x = st[S_OUT-1];
    for (int k = 0; k < 3; k++) begin
      sr       = sat32(add_rounded(x.pos[k], round_dt($signed(x.pd[k]))));
      x.pos[k] = sr.val;
      x.sat    = x.sat | sr.sat;
    end
    if (be) begin
      st[S_OUT] <= x;
    end
  end

  assign new_pos       = st[NST-1].pos;
  assign new_vel       = st[NST-1].vel;
  assign speed_clamped = st[NST-1].clamp;
  assign saturated     = st[NST-1].sat;

endmodule

// File: tb/sv/tb_euler_integrate_speed_clamp_top.sv
`timescale 1ns / 1ps

module tb_euler_integrate_speed_clamp_top;
  import eisc_pkg::*;

  typedef struct {
    logic [31:0] px, py, pz, vx, vy, vz;
    logic        clamped;
    logic        sat;
  } step_res_t;

  typedef struct {
    logic [31:0] p[3];
    logic [31:0] v[3];
    logic [31:0] a[3];
    logic [30:0] lim;
    logic        has_lim;
  } particle_t;

  class euler_scoreboard;
    step_res_t   pending[$];
    logic [15:0] dt;
    logic [30:0] dflt_limit;
    int          errors;

    function new();
      dt = TIME_STEP_RST;
      dflt_limit = DEFAULT_LIMIT_RST;
      errors = 0;
    endfunction

    function longint scale_dt(longint x);
      longint prod;
      prod = x * longint'(dt) + 64'sd32768;
      return prod >>> 16;
    endfunction

    function longint clip32(longint x, inout logic sat);
      if (x > 64'sd2147483647) begin
        sat = 1'b1;
        return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return x;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_particle(particle_t it);
      longint          vel[3], np[3];
      longint unsigned mag[3];
      longint unsigned ssq, lim, m;
      logic            sat, clamped;
      step_res_t       r;
      sat = 1'b0;
      clamped = 1'b0;
      ssq = 0;
      lim = it.has_lim ? 64'(it.lim) : 64'(dflt_limit);
      for (int k = 0; k < 3; k++) begin
        vel[k] = clip32(longint'($signed(it.v[k])) +
                        scale_dt(longint'($signed(it.a[k]))), sat);
        mag[k] = vel[k] < 0 ? -vel[k] : vel[k];
        ssq += mag[k] * mag[k];
      end
      if (ssq > lim * lim) begin
        m = root_floor(ssq);
        clamped = 1'b1;
        for (int k = 0; k < 3; k++)
          vel[k] = vel[k] < 0 ? -longint'((mag[k] * lim) / m) : longint'((mag[k] * lim) / m);
      end
      for (int k = 0; k < 3; k++)
        np[k] = clip32(longint'($signed(it.p[k])) + scale_dt(vel[k]), sat);
      r.px = 32'(np[0]); r.py = 32'(np[1]); r.pz = 32'(np[2]);
      r.vx = 32'(vel[0]); r.vy = 32'(vel[1]); r.vz = 32'(vel[2]);
      r.clamped = clamped;
      r.sat = sat;
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s expected %h got %h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(step_res_t got);
      step_res_t e;
      if (pending.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("new_pos_x", e.px, got.px);
      cmp("new_pos_y", e.py, got.py);
      cmp("new_pos_z", e.pz, got.pz);
      cmp("new_vel_x", e.vx, got.vx);
      cmp("new_vel_y", e.vy, got.vy);
      cmp("new_vel_z", e.vz, got.vz);
      cmp("speed_clamped", 32'(e.clamped), 32'(got.clamped));
      cmp("saturated", 32'(e.sat), 32'(got.sat));
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
  logic [30:0] speed_limit;
  logic limit_present;
  logic out_valid, out_ready;
  logic signed [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
  logic speed_clamped, saturated;

  euler_integrate_speed_clamp_top u_top (.*);

  euler_scoreboard sb = new();
  bit   hold_sink;
  int   cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1; cfg_valid = 0; cfg_index = REG_TIME_STEP; cfg_data = 0;
    in_valid = 0; out_ready = 0; hold_sink = 0;
    {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z} = '0;
    speed_limit = 0; limit_present = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[euler_integrate_speed_clamp_top] ERROR");
      $finish;
    end
  end
  initial cycles = 0;

  // output sink: random stalls, long hold-off when asked
  initial begin
    int w;
    step_res_t got;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        out_ready <= 0;
        @(posedge clk);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (w > 0) begin
          out_ready <= 0;
          repeat (w) @(posedge clk);
        end
        out_ready <= 1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        got.px = new_pos_x; got.py = new_pos_y; got.pz = new_pos_z;
        got.vx = new_vel_x; got.vy = new_vel_y; got.vz = new_vel_z;
        got.clamped = speed_clamped; got.sat = saturated;
        sb.check_result(got);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == REG_TIME_STEP) sb.dt = data[15:0];
    else if (idx == REG_DEFAULT_LIMIT) sb.dflt_limit = data[30:0];
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send(particle_t it, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 4) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    pos_x <= it.p[0]; pos_y <= it.p[1]; pos_z <= it.p[2];
    vel_x <= it.v[0]; vel_y <= it.v[1]; vel_z <= it.v[2];
    acc_x <= it.a[0]; acc_y <= it.a[1]; acc_z <= it.a[2];
    speed_limit <= it.lim; limit_present <= it.has_lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_particle(it);
  endtask

  function automatic logic [31:0] rnd_word(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $signed($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200;
      default: return $signed($urandom_range(0, 2 * 65536 * 5000)) - 65536 * 5000;
    endcase
  endfunction

  function automatic particle_t rnd_particle();
    particle_t it;
    int mode;
    mode = $urandom_range(0, 9);
    mode = mode < 1 ? 0 : (mode < 2 ? 1 : (mode < 6 ? 2 : 3));
    for (int k = 0; k < 3; k++) begin
      it.p[k] = rnd_word($urandom_range(0, 7) == 0 ? 0 : mode);
      it.v[k] = rnd_word(mode);
      it.a[k] = rnd_word(mode);
    end
    case ($urandom_range(0, 3))
      0: it.lim = $urandom();
      1: it.lim = 0;
      default: it.lim = $urandom_range(0, 65536 * 300);
    endcase
    it.has_lim = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic particle_t mk(logic [31:0] p, logic [31:0] v, logic [31:0] a,
                                   logic [30:0] lim, logic has);
    particle_t it;
    for (int k = 0; k < 3; k++) begin
      it.p[k] = p; it.v[k] = v; it.a[k] = a;
    end
    it.lim = lim; it.has_lim = has;
    return it;
  endfunction

  initial begin
    particle_t it;
    bit gaps;
    @(posedge clk);
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero velocity, zero limit, exact limit
    send(mk(0, 0, 0, 0, 1), 1);
    send(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1), 1);
    send(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1), 1);
    send(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), 1);
    send(mk(65536, 65536, 0, 0, 1), 1);
    send(mk(0, 65536 * 2000, 65536, 0, 0), 1);
    send(mk(0, 32'hFFFF_8000, 32'h8000_0000, 31'h7FFF_FFFF, 1), 1);
    it = mk(0, 0, 0, 65536 * 5, 1);
    it.v[0] = 65536 * 3; it.v[1] = 65536 * 4;
    send(it, 1);
    it.lim = 65536 * 5 - 1;
    send(it, 1);
    it.v[0] = -65536 * 3; it.v[2] = 32'h8000_0000;
    send(it, 1);
    drain();
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(REG_DEFAULT_LIMIT, 32'hFFFF_FFFF);
    write_reg(2'd3, 32'h1234_5678);
    send(mk(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0), 1);
    send(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0), 1);
    send(mk(32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_8000, 0, 1), 1);
    drain();
    write_reg(REG_TIME_STEP, 0);
    write_reg(REG_DEFAULT_LIMIT, 0);
    send(mk(12345, 65536, 65536, 0, 0), 1);
    send(mk(12345, 0, 0, 0, 0), 1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TIME_STEP, TIME_STEP_RST);
          write_reg(REG_DEFAULT_LIMIT, DEFAULT_LIMIT_RST);
        end
        1: begin
          write_reg(REG_TIME_STEP, $urandom());
          write_reg(REG_DEFAULT_LIMIT, $urandom());
        end
        2: begin
          write_reg(REG_TIME_STEP, 16'hFFFF);
          write_reg(REG_DEFAULT_LIMIT, $urandom_range(0, 65536 * 50));
        end
        3: begin
          write_reg(REG_TIME_STEP, 1);
          write_reg(REG_DEFAULT_LIMIT, 31'h7FFF_FFFF);
        end
        default: begin
          write_reg(REG_TIME_STEP, $urandom_range(0, 4096));
          write_reg(REG_DEFAULT_LIMIT, $urandom_range(0, 65536 * 1000));
        end
      endcase
      for (int i = 0; i < 245; i++) begin
        // hold the sink off for a long stretch while items keep coming
        if (ph == 1 && i == 20) fork
          begin
            hold_sink = 1;
            repeat (300) @(posedge clk);
            hold_sink = 0;
          end
        join_none
        if (ph == 3 && i == 100) drain();
        gaps = (i / 40) % 2 == 0;
        send(rnd_particle(), gaps);
      end
      drain();
    end

    if (sb.errors == 0)
      $display("[euler_integrate_speed_clamp_top] OK");
    else
      $display("[euler_integrate_speed_clamp_top] ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/eisc_pkg.sv
rtl/core/eisc_front.sv
rtl/core/eisc_queue.sv
rtl/core/eisc_back.sv
rtl/core/euler_integrate_speed_clamp_top.sv
tb/sv/tb_euler_integrate_speed_clamp_top.sv
